// ===== rtl/lsjs_pkg.sv =====
// Shared types and constants for the laser scan jump segmenter.
// No dependencies; imported by lsjs_dist and laser_scan_jump_segmenter_top.
`default_nettype none

package lsjs_pkg;

  // Port widths, fixed by the interface
  localparam int PointW    = 16;
  localparam int SegLabelW = 16;
  localparam int ThreshW   = 35;

  // Internal label and coordinate widths
  localparam int LabelBits = 16;
  localparam int CoordBits = 16;

  // Distance arithmetic widths
  localparam int DiffW = CoordBits + 1;
  localparam int SumW  = 2 * DiffW;
  localparam int CmpW  = (SumW > ThreshW) ? SumW : ThreshW;

  localparam logic [ThreshW-1:0] ThreshReset = ThreshW'(90000);

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic [LabelBits-1:0]        label_t;
  typedef logic [ThreshW-1:0]          thresh_t;
  typedef logic [1:0]                  cnt_t;

  typedef enum logic [1:0] {
    JOIN_CONT   = 2'd0,
    JOIN_SECOND = 2'd1,
    JOIN_THIRD  = 2'd2,
    JOIN_NEW    = 2'd3
  } join_e;

  // Place of the current segment in the closed list
  typedef enum logic [1:0] {
    POS_OPEN   = 2'd0,
    POS_LAST   = 2'd1,
    POS_SECOND = 2'd2,
    POS_THIRD  = 2'd3
  } pos_e;

  typedef struct packed {
    label_t lbl;
    coord_t x;
    coord_t y;
  } closed_t;

endpackage

`default_nettype wire

// ===== rtl/lsjs_dist.sv =====
// Squared-distance jump compare between two points.
// Depends on lsjs_pkg.
`default_nettype none

module lsjs_dist (
  input  lsjs_pkg::coord_t  a_x_i,
  input  lsjs_pkg::coord_t  a_y_i,
  input  lsjs_pkg::coord_t  b_x_i,
  input  lsjs_pkg::coord_t  b_y_i,
  input  lsjs_pkg::thresh_t thresh_i,
  output logic              jump_o
);
  import lsjs_pkg::*;

  logic signed [DiffW-1:0]   dx, dy;
  logic signed [2*DiffW-1:0] sqx, sqy;
  logic [SumW-1:0]           sum;

  always_comb begin
    dx     = DiffW'(a_x_i) - DiffW'(b_x_i);
    dy     = DiffW'(a_y_i) - DiffW'(b_y_i);
    sqx    = dx * dx;
    sqy    = dy * dy;
    sum    = SumW'($unsigned(sqx)) + SumW'($unsigned(sqy));
    jump_o = CmpW'(sum) > CmpW'(thresh_i);
  end

endmodule

`default_nettype wire

// ===== rtl/laser_scan_jump_segmenter_top.sv =====
// Laser scan jump segmenter, top level.
// Depends on lsjs_pkg and lsjs_dist.
// A word accepted into the input stage register passes to the result
// register as the stage drains. Throughput: one word per cycle while the
// result register is not stalled; the segment update is combinational.
// Reset (rst_ni low, async): threshold 90000, segment state but closed list
// cleared, labels restart at 0 current / 1 next, both pipeline stages empty.
`default_nettype none

module laser_scan_jump_segmenter_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // config write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lsjs_pkg::ThreshW-1:0]   cfg_jump_distance_sq_i,
  // point input channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [lsjs_pkg::PointW-1:0] point_x_i,
  input  logic signed [lsjs_pkg::PointW-1:0] point_y_i,
  input  logic                           point_valid_i,
  input  logic                           scan_start_i,
  // label output channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [lsjs_pkg::SegLabelW-1:0] segment_label_o,
  output logic                           skipped_o,
  output lsjs_pkg::join_e                join_kind_o
);
  import lsjs_pkg::*;

  // ---------------------------------------------------------------
  // Handshake: input stage register, then result register.
  // The stage drains whenever the result register is empty or taken.
  // ---------------------------------------------------------------
  logic    advance, fire, in_acc;

  logic    stg_valid_q, stg_valid_d;
  coord_t  stg_x_q, stg_y_q;
  logic    stg_pv_q, stg_ss_q;

  logic    out_valid_q, out_valid_d;
  logic [SegLabelW-1:0] out_label_q, out_label_d;
  logic    out_skip_q, out_skip_d;
  join_e   out_kind_q, out_kind_d;

  thresh_t thresh_q;

  assign cfg_ready_o = 1'b1;
  assign advance     = !out_valid_q || !out_stall_i;
  assign fire        = stg_valid_q && advance;
  assign in_stall_o  = stg_valid_q && !advance;
  assign in_acc      = in_valid_i && !in_stall_o;

  assign out_valid_o     = out_valid_q;
  assign segment_label_o = out_label_q;
  assign skipped_o       = out_skip_q;
  assign join_kind_o     = out_kind_q;

  // ---------------------------------------------------------------
  // Segment state
  // ---------------------------------------------------------------
  coord_t  prev_x_q, prev_y_q, prev_x_d, prev_y_d;
  logic    have_prev_q, have_prev_d;
  label_t  cur_lbl_q, cur_lbl_d;
  pos_e    cur_pos_q, cur_pos_d;
  label_t  next_lbl_q, next_lbl_d;
  cnt_t    cnt_q, cnt_d;
  closed_t closed_q [3];
  closed_t closed_d [3];

  // state as seen after an optional scan-start clear
  logic    have_prev_e;
  label_t  cur_lbl_e, next_lbl_e;
  pos_e    cur_pos_e;
  cnt_t    cnt_e;

  // rejoin candidates after the closing update
  coord_t  c1_x, c1_y, c2_x, c2_y;
  label_t  c1_lbl, c2_lbl;

  logic    jump_prev, jump_c1, jump_c2, jumped;

  always_comb begin
    have_prev_e = have_prev_q && !stg_ss_q;
    cur_lbl_e   = stg_ss_q ? '0 : cur_lbl_q;
    cur_pos_e   = stg_ss_q ? POS_OPEN : cur_pos_q;
    next_lbl_e  = stg_ss_q ? LabelBits'(1) : next_lbl_q;
    cnt_e       = stg_ss_q ? '0 : cnt_q;
  end

  // the previous point itself, compared against this one
  lsjs_dist u_dist_prev (
    .a_x_i   (prev_x_q),
    .a_y_i   (prev_y_q),
    .b_x_i   (stg_x_q),
    .b_y_i   (stg_y_q),
    .thresh_i(thresh_q),
    .jump_o  (jump_prev)
  );

  // candidates: entries 1 and 2 of the closed list once the current
  // segment has been closed (shift) or refreshed (new last point)
  always_comb begin
    unique case (cur_pos_e)
      POS_OPEN: begin
        c1_lbl = closed_q[0].lbl; c1_x = closed_q[0].x; c1_y = closed_q[0].y;
        c2_lbl = closed_q[1].lbl; c2_x = closed_q[1].x; c2_y = closed_q[1].y;
      end
      POS_SECOND: begin
        c1_lbl = closed_q[1].lbl; c1_x = prev_x_q;      c1_y = prev_y_q;
        c2_lbl = closed_q[2].lbl; c2_x = closed_q[2].x; c2_y = closed_q[2].y;
      end
      POS_THIRD: begin
        c1_lbl = closed_q[1].lbl; c1_x = closed_q[1].x; c1_y = closed_q[1].y;
        c2_lbl = closed_q[2].lbl; c2_x = prev_x_q;      c2_y = prev_y_q;
      end
      default: begin  // last: entry 0 refreshed, 1 and 2 untouched
        c1_lbl = closed_q[1].lbl; c1_x = closed_q[1].x; c1_y = closed_q[1].y;
        c2_lbl = closed_q[2].lbl; c2_x = closed_q[2].x; c2_y = closed_q[2].y;
      end
    endcase
  end

  lsjs_dist u_dist_c1 (
    .a_x_i   (c1_x),
    .a_y_i   (c1_y),
    .b_x_i   (stg_x_q),
    .b_y_i   (stg_y_q),
    .thresh_i(thresh_q),
    .jump_o  (jump_c1)
  );

  lsjs_dist u_dist_c2 (
    .a_x_i   (c2_x),
    .a_y_i   (c2_y),
    .b_x_i   (stg_x_q),
    .b_y_i   (stg_y_q),
    .thresh_i(thresh_q),
    .jump_o  (jump_c2)
  );

  assign jumped = have_prev_e && jump_prev;

  always_comb begin
    prev_x_d    = prev_x_q;
    prev_y_d    = prev_y_q;
    have_prev_d = have_prev_e;
    cur_lbl_d   = cur_lbl_e;
    cur_pos_d   = cur_pos_e;
    next_lbl_d  = next_lbl_e;
    cnt_d       = cnt_e;
    for (int i = 0; i < 3; i++) begin
      closed_d[i] = closed_q[i];
    end

    out_label_d = '0;
    out_skip_d  = 1'b1;
    out_kind_d  = JOIN_CONT;

    if (stg_pv_q) begin
      out_skip_d = 1'b0;
      if (jumped) begin
        // close or refresh the segment just left
        unique case (cur_pos_e)
          POS_OPEN: begin
            closed_d[2] = closed_q[1];
            closed_d[1] = closed_q[0];
            closed_d[0] = '{lbl: cur_lbl_e, x: prev_x_q, y: prev_y_q};
            if (cnt_e != 2'd3) begin
              cnt_d = cnt_e + 2'd1;
            end
          end
          POS_LAST: begin
            closed_d[0].x = prev_x_q;
            closed_d[0].y = prev_y_q;
          end
          POS_SECOND: begin
            closed_d[1].x = prev_x_q;
            closed_d[1].y = prev_y_q;
          end
          POS_THIRD: begin
            closed_d[2].x = prev_x_q;
            closed_d[2].y = prev_y_q;
          end
          default: ;
        endcase

        priority if (cnt_d >= 2'd2 && !jump_c1) begin
          cur_lbl_d  = c1_lbl;
          cur_pos_d  = POS_SECOND;
          out_kind_d = JOIN_SECOND;
        end else if (cnt_d == 2'd3 && !jump_c2) begin
          cur_lbl_d  = c2_lbl;
          cur_pos_d  = POS_THIRD;
          out_kind_d = JOIN_THIRD;
        end else begin
          cur_lbl_d  = next_lbl_e;
          cur_pos_d  = POS_OPEN;
          next_lbl_d = next_lbl_e + LabelBits'(1);
          out_kind_d = JOIN_NEW;
        end
      end
      prev_x_d    = stg_x_q;
      prev_y_d    = stg_y_q;
      have_prev_d = 1'b1;
      out_label_d = SegLabelW'(cur_lbl_d);
    end
  end

  always_comb begin
    if (in_acc) begin
      stg_valid_d = 1'b1;
    end else if (advance) begin
      stg_valid_d = 1'b0;
    end else begin
      stg_valid_d = stg_valid_q;
    end
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      thresh_q    <= ThreshReset;
      have_prev_q <= 1'b0;
      cur_lbl_q   <= '0;
      cur_pos_q   <= POS_OPEN;
      next_lbl_q  <= LabelBits'(1);
      cnt_q       <= '0;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
    end else begin
      stg_valid_q <= stg_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        thresh_q <= cfg_jump_distance_sq_i;
      end
      if (fire) begin
        have_prev_q <= have_prev_d;
        cur_lbl_q   <= cur_lbl_d;
        cur_pos_q   <= cur_pos_d;
        next_lbl_q  <= next_lbl_d;
        cnt_q       <= cnt_d;
        prev_x_q    <= prev_x_d;
        prev_y_q    <= prev_y_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      stg_x_q  <= CoordBits'(point_x_i);
      stg_y_q  <= CoordBits'(point_y_i);
      stg_pv_q <= point_valid_i;
      stg_ss_q <= scan_start_i;
    end
    if (fire) begin
      out_label_q <= out_label_d;
      out_skip_q  <= out_skip_d;
      out_kind_q  <= out_kind_d;
      for (int i = 0; i < 3; i++) begin
        closed_q[i] <= closed_d[i];
      end
    end
  end

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  // a closed segment is only ever rejoined as second- or third-last
  a_pos_never_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_pos_q != POS_LAST)
    else $error("current segment marked as last closed");

  a_pos_second_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_pos_q == POS_SECOND |-> cnt_q >= 2'd2)
    else $error("rejoined second-last with fewer than two closed");

  a_pos_third_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_pos_q == POS_THIRD |-> cnt_q == 2'd3)
    else $error("rejoined third-last with fewer than three closed");

  a_skip_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && skipped_o |-> segment_label_o == '0 && join_kind_o == JOIN_CONT)
    else $error("skipped word carries a label");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> stg_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled with room in the pipe");

endmodule

`default_nettype wire
